// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/b64le_pkg.sv
// ----------------------------------------------------------------------------
// Base64 line encoder package
// Constants, types and the symbol alphabet of the encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

  localparam int unsigned LINE_CHARS_DEFAULT = 64;
  localparam int unsigned LINE_W = 6;

  localparam logic [7:0] PAD_CHAR = 8'd61;
  localparam logic [7:0] CR_CHAR  = 8'd13;
  localparam logic [7:0] LF_CHAR  = 8'd10;

  typedef enum logic [1:0] {
    LS_CHAR,
    LS_CR,
    LS_LF
  } line_state_t;

  function automatic logic [7:0] sym_to_ascii(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = 8'd65 + w;
    end else if (v < 6'd52) begin
      c = 8'd71 + w;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// File: rtl/b64le_ifs.sv
// ----------------------------------------------------------------------------
// Base64 line encoder channels
// Valid/ready channels for message bytes and for output characters.
// ----------------------------------------------------------------------------
interface b64le_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64le_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

// File: rtl/base64_lsb_first_line_encoder.sv
// The first character of a byte enters the output register from the character buffer once
// the byte is accepted and the output can advance.
// Throughput: one character per cycle through the output register while char_stream.ready
// does not stall it; a byte causes one to six characters, usually one or two.
// A new byte is accepted in the cycle in which the previous byte's last character enters the
// output register.
// Reset (rst, synchronous) empties the buffer and output and clears group and line state.
// ----------------------------------------------------------------------------
// Base64 LSB-first line encoder
// Encodes message bytes into base64 characters with padding and CR LF wrap.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_lsb_first_line_encoder #(
  parameter int unsigned LINE_CHARS = b64le_pkg::LINE_CHARS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  b64le_in_if.sink     byte_stream,
  b64le_out_if.source  char_stream
);

  logic [5:0]             carry_bits;
  logic [1:0]             group_phase;
  logic [b64le_pkg::LINE_W-1:0] line_count;

  logic [7:0]             chars [4];
  logic [1:0]             last_idx;
  logic [1:0]             idx;
  logic                   eom;
  logic                   end_pend;
  logic                   busy;
  b64le_pkg::line_state_t state;
  b64le_pkg::line_state_t state_next;

  logic                   out_valid;
  logic [7:0]             out_char;
  logic                   last_of_run;

  logic                   adv;
  logic                   step;
  logic                   accept;
  logic [b64le_pkg::LINE_W-1:0] line_inc;
  logic                   line_full;
  logic [7:0]             emit_char;
  logic                   emit_last;

  logic [7:0]             new_chars [4];
  logic [1:0]             new_last_idx;
  logic [5:0]             carry_next;
  logic [1:0]             group_phase_next;
  logic [7:0]             b;

  assign adv       = !out_valid || char_stream.ready;
  assign step      = busy && adv;
  assign line_inc  = line_count + 6'd1;
  assign line_full = ({1'b0, line_inc} >= 7'(LINE_CHARS)) || (line_inc == 6'd0);

  assign byte_stream.ready = !busy || (adv && emit_last);
  assign accept            = byte_stream.valid && byte_stream.ready;

  assign char_stream.valid       = out_valid;
  assign char_stream.out_char    = out_char;
  assign char_stream.last_of_run = last_of_run;

  always_comb begin
    case (state)
      b64le_pkg::LS_CHAR: state_next = line_full ? b64le_pkg::LS_CR : b64le_pkg::LS_CHAR;
      b64le_pkg::LS_CR:   state_next = b64le_pkg::LS_LF;
      b64le_pkg::LS_LF:   state_next = b64le_pkg::LS_CHAR;
      default:            state_next = b64le_pkg::LS_CHAR;
    endcase
  end

  always_comb begin
    case (state)
      b64le_pkg::LS_CHAR: begin
        emit_char = chars[idx];
        emit_last = busy && !line_full && (idx == last_idx);
      end
      b64le_pkg::LS_CR: begin
        emit_char = b64le_pkg::CR_CHAR;
        emit_last = 1'b0;
      end
      b64le_pkg::LS_LF: begin
        emit_char = b64le_pkg::LF_CHAR;
        emit_last = busy && end_pend;
      end
      default: begin
        emit_char = b64le_pkg::LF_CHAR;
        emit_last = 1'b0;
      end
    endcase
  end

  always_comb begin
    b            = byte_stream.data_byte;
    new_chars[0] = b64le_pkg::PAD_CHAR;
    new_chars[1] = b64le_pkg::PAD_CHAR;
    new_chars[2] = b64le_pkg::PAD_CHAR;
    new_chars[3] = b64le_pkg::PAD_CHAR;
    case (group_phase)
      2'd0: begin
        new_chars[0]     = b64le_pkg::sym_to_ascii(b[5:0]);
        new_chars[1]     = b64le_pkg::sym_to_ascii({4'd0, b[7:6]});
        new_last_idx     = byte_stream.end_of_message ? 2'd3 : 2'd0;
        carry_next       = {4'd0, b[7:6]};
        group_phase_next = 2'd1;
      end
      2'd1: begin
        new_chars[0]     = b64le_pkg::sym_to_ascii(carry_bits | {b[3:0], 2'b00});
        new_chars[1]     = b64le_pkg::sym_to_ascii({2'd0, b[7:4]});
        new_last_idx     = byte_stream.end_of_message ? 2'd2 : 2'd0;
        carry_next       = {2'd0, b[7:4]};
        group_phase_next = 2'd2;
      end
      default: begin
        new_chars[0]     = b64le_pkg::sym_to_ascii(carry_bits | {b[1:0], 4'b0000});
        new_chars[1]     = b64le_pkg::sym_to_ascii(b[7:2]);
        new_last_idx     = 2'd1;
        carry_next       = 6'd0;
        group_phase_next = 2'd0;
      end
    endcase
    if (byte_stream.end_of_message) begin
      carry_next       = 6'd0;
      group_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      state       <= b64le_pkg::LS_CHAR;
      carry_bits  <= 6'd0;
      group_phase <= 2'd0;
      line_count  <= '0;
      idx         <= 2'd0;
      end_pend    <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (step) begin
        state <= state_next;
        if (emit_last && eom) begin
          line_count <= '0;
        end else if (state == b64le_pkg::LS_CHAR) begin
          line_count <= line_full ? '0 : line_inc;
        end
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (step && emit_last) begin
        busy <= 1'b0;
      end
      if (accept) begin
        idx <= 2'd0;
      end else if (step && state == b64le_pkg::LS_CHAR) begin
        idx <= idx + 2'd1;
      end
      if (accept) begin
        end_pend <= 1'b0;
      end else if (step && state == b64le_pkg::LS_CHAR && line_full) begin
        end_pend <= (idx == last_idx);
      end
      if (accept) begin
        carry_bits  <= carry_next;
        group_phase <= group_phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      chars    <= new_chars;
      last_idx <= new_last_idx;
      eom      <= byte_stream.end_of_message;
    end
    if (step) begin
      out_char    <= emit_char;
      last_of_run <= emit_last;
    end
  end

  `ASSERT_SAME(a_line_bound, clk, rst, 1'b1, {1'b0, line_count} < 7'(LINE_CHARS))
  `ASSERT_NEXT(a_cr_then_lf, clk, rst,
    out_valid && char_stream.ready && out_char == b64le_pkg::CR_CHAR,
    out_valid && out_char == b64le_pkg::LF_CHAR)
  `ASSERT_NEXT(a_eom_line_reset, clk, rst, step && emit_last && eom, line_count == '0)
  `ASSERT_SAME(a_no_accept_midrun, clk, rst, busy && !emit_last, !byte_stream.ready)

endmodule
